// File: src/wcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcc_pkg
// Shared types and constants of the weighted concordance tree counter.
// ----------------------------------------------------------------------------
package wcc_pkg;

  localparam int unsigned MAX_NODES = 1024;
  localparam int unsigned ADDR_W    = $clog2(MAX_NODES);
  localparam int unsigned NUM_W     = 11;
  localparam int unsigned RANK_W    = 10;
  localparam int unsigned ACC_W     = 54;
  localparam int unsigned Q_W       = 33;

  typedef struct packed {
    logic                     start_req;
    logic [RANK_W-1:0]        outcome_rank;
    logic signed [31:0]       score;
    logic [15:0]              event_weight;
    logic [15:0]              pair_weight;
  } in_item_t;

  typedef struct packed {
    logic [47:0] item_contribution;
    logic [62:0] running_total;
    logic        rank_error;
  } out_item_t;

  typedef struct packed {
    logic [31:0]        own_ws;
    logic [31:0]        left_ws;
    logic signed [31:0] left_ts;
    logic [31:0]        left_tw;
    logic signed [31:0] own_ts;
    logic [31:0]        own_tw;
  } node_t;

  localparam int unsigned NODE_W = $bits(node_t);

  typedef struct packed {
    logic clr_wr;
    logic load;
    logic ex;
    logic ac;
    logic fin;
  } wcc_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic start;
    logic rank_err;
    logic final_node;
    logic out_free;
  } wcc_sts_t;

endpackage

// File: src/wcc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wcc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/wcc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcc_ctrl
// Sequencer: store clearing sweep, per-node read/update/accumulate, result.
// ----------------------------------------------------------------------------
module wcc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  wcc_pkg::wcc_sts_t sts_i,
  output wcc_pkg::wcc_cmd_t cmd_o
);
  import wcc_pkg::*;

  typedef enum logic [2:0] {
    ST_SWEEP, ST_IDLE, ST_CHK, ST_RD, ST_EX, ST_AC, ST_FIN
  } state_e;

  state_e state_q, state_d;
  logic   pend_q, pend_d;

  always_comb begin
    cmd_o        = '0;
    in_ready_o   = (state_q == ST_IDLE);
    state_d      = state_q;
    pend_d       = pend_q;
    case (state_q)
      ST_SWEEP: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = pend_q ? ST_CHK : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHK;
        end
      end
      ST_CHK: begin
        if (sts_i.start && !pend_q) begin
          pend_d  = 1'b1;
          state_d = ST_SWEEP;
        end else begin
          pend_d  = 1'b0;
          state_d = sts_i.rank_err ? ST_FIN : ST_RD;
        end
      end
      ST_RD: state_d = ST_EX;
      ST_EX: begin
        cmd_o.ex = 1'b1;
        state_d  = ST_AC;
      end
      ST_AC: begin
        cmd_o.ac = 1'b1;
        state_d  = sts_i.final_node ? ST_FIN : ST_RD;
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

endmodule

// File: src/wcc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcc_datapath
// Node store, tree walk registers, tie-cut arithmetic, accumulator, result.
// ----------------------------------------------------------------------------
module wcc_datapath (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [10:0]             cfg_wdata_i,
  input  wcc_pkg::in_item_t       in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output wcc_pkg::out_item_t      out_data_o,
  input  wcc_pkg::wcc_cmd_t       cmd_i,
  output wcc_pkg::wcc_sts_t       sts_o
);
  import wcc_pkg::*;

  localparam logic [NUM_W-1:0]  MaxNum  = NUM_W'(MAX_NODES);
  localparam logic [ADDR_W-1:0] LastAdr = ADDR_W'(MAX_NODES - 1);

  function automatic logic [31:0] add_sat32(input logic [31:0] a, input logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + 33'(b);
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  logic [NUM_W-1:0]  num_q;
  in_item_t          item_q;
  logic              err_q;
  logic [RANK_W-1:0] lo_q, hi_q, cur_q;
  logic [RANK_W-1:0] lo_d, hi_d;
  logic [RANK_W:0]   mid;
  logic [Q_W-1:0]    q_q, q_d;
  logic              final_q;
  logic [ACC_W-1:0]  acc_q;
  logic [62:0]       total_q;
  logic              out_valid_q;
  out_item_t         out_q;
  logic [ADDR_W-1:0] clr_q;

  logic [NUM_W-1:0]  m;
  logic              rank_err;
  logic [RANK_W-1:0] root_hi;
  node_t             rd, nd;
  logic              we;
  logic              at_final, go_left;
  logic signed [34:0] mass;
  logic [47:0]       contrib;
  logic [63:0]       tsum;

  assign m        = (num_q > MaxNum) ? MaxNum : num_q;
  assign rank_err = {1'b0, in_data_i.outcome_rank} >= m;
  assign root_hi  = RANK_W'(m - NUM_W'(1));

  wcc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cmd_i.clr_wr ? clr_q : ADDR_W'(cur_q)),
    .wdata_i (cmd_i.clr_wr ? '0 : nd),
    .raddr_i (ADDR_W'(cur_q)),
    .rdata_o (rd)
  );

  // Node update and qualifying mass for the node under visit.
  always_comb begin
    nd       = rd;
    q_d      = '0;
    lo_d     = lo_q;
    hi_d     = hi_q;
    at_final = (item_q.outcome_rank == cur_q);
    go_left  = (item_q.outcome_rank < cur_q);
    mass     = '0;
    if (at_final) begin
      if (rd.own_tw == '0 || item_q.score > rd.own_ts) begin
        nd.own_ts = item_q.score;
        nd.own_tw = 32'(item_q.pair_weight);
      end else begin
        nd.own_tw = add_sat32(rd.own_tw, item_q.pair_weight);
      end
      nd.own_ws = add_sat32(rd.own_ws, item_q.pair_weight);
      mass = 35'(rd.left_ws);
      if (item_q.score == rd.left_ts) mass = mass - 35'(rd.left_tw);
    end else if (go_left) begin
      nd.left_ws = add_sat32(rd.left_ws, item_q.pair_weight);
      if (rd.left_tw == '0 || item_q.score > rd.left_ts) begin
        nd.left_ts = item_q.score;
        nd.left_tw = 32'(item_q.pair_weight);
      end else begin
        nd.left_tw = add_sat32(rd.left_tw, item_q.pair_weight);
      end
      hi_d = cur_q - RANK_W'(1);
    end else begin
      mass = 35'(rd.own_ws) + 35'(rd.left_ws);
      if (item_q.score == rd.left_ts) mass = mass - 35'(rd.left_tw);
      if (item_q.score == rd.own_ts)  mass = mass - 35'(rd.own_tw);
      lo_d = cur_q + RANK_W'(1);
    end
    q_d = mass[34] ? '0 : mass[Q_W-1:0];
  end

  assign mid = ({1'b0, lo_d} + {1'b0, hi_d}) >> 1;
  assign we  = cmd_i.clr_wr || (cmd_i.ex && (at_final || go_left));

  assign contrib = (acc_q > ACC_W'(48'hFFFF_FFFF_FFFF)) ? 48'hFFFF_FFFF_FFFF
                                                        : acc_q[47:0];
  assign tsum    = {1'b0, total_q} + 64'(contrib);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
      err_q  <= rank_err;
      lo_q   <= '0;
      hi_q   <= root_hi;
      cur_q  <= root_hi >> 1;
      acc_q  <= '0;
    end
    if (cmd_i.ex) begin
      q_q     <= q_d;
      final_q <= at_final;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
    end
    if (cmd_i.ac) begin
      acc_q <= acc_q + ACC_W'(item_q.event_weight * q_q);
      if (!final_q) cur_q <= mid[RANK_W-1:0];
    end
    if (cmd_i.fin) begin
      out_q.rank_error        <= err_q;
      out_q.item_contribution <= err_q ? '0 : contrib;
      out_q.running_total     <= err_q ? total_q
                                       : (tsum[63] ? '1 : tsum[62:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q       <= NUM_W'(1);
      total_q     <= '0;
      out_valid_q <= 1'b0;
      clr_q       <= '0;
    end else begin
      if (cfg_we_i) num_q <= cfg_wdata_i;
      if (cmd_i.load && in_data_i.start_req) begin
        total_q <= '0;
      end else if (cmd_i.fin && !err_q) begin
        total_q <= tsum[63] ? '1 : tsum[62:0];
      end
      if (cmd_i.clr_wr) clr_q <= (clr_q == LastAdr) ? '0 : clr_q + ADDR_W'(1);
      if (cmd_i.fin) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.clr_last   = (clr_q == LastAdr);
  assign sts_o.start      = item_q.start_req;
  assign sts_o.rank_err   = err_q;
  assign sts_o.final_node = final_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: src/weighted_concordance_tree_counter_unit.sv
`timescale 1ns / 1ps
// Sequence: the sequencer loads the beat, checks its rank, then reads, updates and
//   accumulates per visited tree node (up to 11 nodes at 1024 ranks) before the
//   result state; an out-of-range rank goes straight to the result.
// Throughput: one item at a time; the next beat is taken in the cycle after the
//   result is posted. A start beat first sweeps every node address to zero.
// Reset: asynchronous, active low; after reset the node RAM is swept to zero
//   before the first beat is taken.
// ----------------------------------------------------------------------------
// weighted_concordance_tree_counter_unit
// Weighted concordant-pair counter over an implicit balanced search tree.
// ----------------------------------------------------------------------------
module weighted_concordance_tree_counter_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [10:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  wcc_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output wcc_pkg::out_item_t  out_data_o
);
  import wcc_pkg::*;

  // Command and status between sequencer and datapath.
  wcc_cmd_t cmd;
  wcc_sts_t sts;

  // Sequencer: holds the clear sweep, walks the tree node by node (read, update, accumulate).
  wcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: node RAM, walk bounds, tie cut, multiply-accumulate, result beat.
  wcc_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// File: sim/wcc_beat_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcc_beat_checker
// Watches both beat channels of the concordance counter, predicts every
// result from its own copy of the tree sums and compares field by field.
// ----------------------------------------------------------------------------
module wcc_beat_checker
  import wcc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_data_i,
  output int        fail_count_o,
  output int        pending_o,
  output int        seen_results_o,
  output int        seen_rank_errors_o
);

  localparam logic [31:0] W_SAT = 32'hFFFF_FFFF;
  localparam logic [63:0] C_SAT = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [63:0] T_SAT = 64'h7FFF_FFFF_FFFF_FFFF;

  logic [10:0] node_count;
  int unsigned own_mass   [MAX_NODES];
  int unsigned left_mass  [MAX_NODES];
  int          left_top_s [MAX_NODES];
  int unsigned left_top_w [MAX_NODES];
  int          own_top_s  [MAX_NODES];
  int unsigned own_top_w  [MAX_NODES];
  logic [63:0] concord_total;
  out_item_t   expected_results[$];

  function automatic int unsigned add_w(int unsigned a, int unsigned b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? W_SAT : s[31:0];
  endfunction

  function automatic void clear_tree();
    for (int n = 0; n < MAX_NODES; n++) begin
      own_mass[n] = 0; left_mass[n] = 0; left_top_s[n] = 0;
      left_top_w[n] = 0; own_top_s[n] = 0; own_top_w[n] = 0;
    end
    concord_total = '0;
  endfunction

  // Restart the top group on a higher score or an empty group, else merge.
  function automatic void bump_top(inout int ts, inout int unsigned tw,
                                   input int s, input int unsigned v);
    if (tw == 0 || s > ts) begin
      ts = s;
      tw = v;
    end else begin
      tw = add_w(tw, v);
    end
  endfunction

  function automatic longint unsigned drop_ties(longint mass, int s, int ts,
                                                int unsigned tw);
    if (s == ts) mass -= longint'(tw);
    return (mass < 0) ? 0 : mass;
  endfunction

  function automatic out_item_t predict_concordance(in_item_t b);
    out_item_t   r;
    int unsigned m, rank, lo, hi, cur, u, v;
    int          s;
    logic [63:0] acc;
    longint      mass;
    if (b.start_req) clear_tree();
    m    = (node_count > MAX_NODES) ? MAX_NODES : node_count;
    rank = b.outcome_rank;
    s    = b.score;
    u    = b.event_weight;
    v    = b.pair_weight;
    acc  = '0;
    if (rank >= m) begin
      r.item_contribution = '0;
      r.running_total     = concord_total[62:0];
      r.rank_error        = 1'b1;
      return r;
    end
    lo = 0;
    hi = m - 1;
    cur = (lo + hi) / 2;
    while (cur != rank) begin
      if (rank < cur) begin
        left_mass[cur] = add_w(left_mass[cur], v);
        bump_top(left_top_s[cur], left_top_w[cur], s, v);
        hi = cur - 1;
      end else begin
        mass = longint'(own_mass[cur]) + longint'(left_mass[cur]);
        if (s == left_top_s[cur]) mass -= longint'(left_top_w[cur]);
        acc += 64'(u) * drop_ties(mass, s, own_top_s[cur], own_top_w[cur]);
        lo = cur + 1;
      end
      cur = (lo + hi) / 2;
    end
    bump_top(own_top_s[cur], own_top_w[cur], s, v);
    own_mass[cur] = add_w(own_mass[cur], v);
    acc += 64'(u) * drop_ties(longint'(left_mass[cur]), s, left_top_s[cur],
                              left_top_w[cur]);
    if (acc > C_SAT) acc = C_SAT;
    concord_total = (concord_total + acc > T_SAT) ? T_SAT : concord_total + acc;
    r.item_contribution = acc[47:0];
    r.running_total     = concord_total[62:0];
    r.rank_error        = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      node_count = 11'd1;
      clear_tree();
      expected_results.delete();
      fail_count_o = 0;
      seen_results_o = 0;
      seen_rank_errors_o = 0;
    end else begin
      if (cfg_we_i) node_count = cfg_wdata_i;
      if (in_valid_i && in_ready_i)
        expected_results.push_back(predict_concordance(in_data_i));
      if (out_valid_i && out_ready_i) begin
        seen_results_o++;
        if (out_data_i.rank_error) seen_rank_errors_o++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected beat", 64'(out_data_i.running_total), '0);
        end else begin
          want = expected_results.pop_front();
          if (out_data_i.item_contribution !== want.item_contribution)
            report_mismatch("item_contribution", 64'(out_data_i.item_contribution),
                            64'(want.item_contribution));
          if (out_data_i.running_total !== want.running_total)
            report_mismatch("running_total", 64'(out_data_i.running_total),
                            64'(want.running_total));
          if (out_data_i.rank_error !== want.rank_error)
            report_mismatch("rank_error", 64'(out_data_i.rank_error),
                            64'(want.rank_error));
        end
      end
    end
    pending_o = expected_results.size();
  end

endmodule

// File: sim/tb_weighted_concordance_tree_counter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_weighted_concordance_tree_counter_unit
// Drives score-ordered item groups with random weights, ties and ranks
// through several tree sizes; the checker beside the block judges results.
// ----------------------------------------------------------------------------
module tb_weighted_concordance_tree_counter_unit;
  import wcc_pkg::*;

  localparam int QUIET_LIMIT = 6000;   // start sweep + long hold + slack
  localparam int DRAIN_WAIT  = 60;     // a bit more than the worst walk
  localparam int LONG_HOLD   = 400;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we = 1'b0;
  logic [10:0] cfg_wdata = '0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int fail_count, pending, seen_results, seen_rank_errors;
  int quiet_cycles = 0;
  bit long_hold_req = 1'b0;
  int unsigned node_setting = 1;
  longint group_score;

  always #5 clk_i = ~clk_i;

  weighted_concordance_tree_counter_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  wcc_beat_checker chk (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_ready_i         (in_ready),
    .in_data_i          (in_data),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready),
    .out_data_i         (out_data),
    .fail_count_o       (fail_count),
    .pending_o          (pending),
    .seen_results_o     (seen_results),
    .seen_rank_errors_o (seen_rank_errors)
  );

  // Watchdog: count cycles in which neither channel moves a beat.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", quiet_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: switch stall mood at random now and then; on request hold off
  // for a long stretch so the block backs up into its input.
  initial begin
    int mood;
    mood = 0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        long_hold_req = 1'b0;
      end
      if ($urandom_range(63) == 0) mood = $urandom_range(3);
      case (mood)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(1) == 1);
        2: out_ready <= ($urandom_range(9) == 0);
        default: out_ready <= ($urandom_range(3) != 0);
      endcase
    end
  end

  // Offer one beat at the current falling edge, hold until taken, then
  // advance to the next falling edge.
  task automatic send_beat(input in_item_t beat);
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
  endtask

  task automatic idle_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // Write the size register only with nothing in flight.
  task automatic set_node_count(input int unsigned value);
    idle_sender(1);
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value[10:0];
    @(negedge clk_i);
    cfg_we <= 1'b0;
    node_setting = value;
  endtask

  function automatic in_item_t make_beat(bit start, int unsigned rank, int score,
                                         int unsigned u, int unsigned v);
    in_item_t b;
    b.start_req    = start;
    b.outcome_rank = rank[RANK_W-1:0];
    b.score        = score;
    b.event_weight = u[15:0];
    b.pair_weight  = v[15:0];
    return b;
  endfunction

  // Next score of the current group: mostly ascending with many ties, now
  // and then broken order or a full-range value.
  function automatic int next_score();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30)      group_score = group_score;
    else if (pick < 80) group_score = group_score + $urandom_range(4096);
    else if (pick < 92) group_score = group_score + $urandom;
    else if (pick < 96) group_score = group_score - $urandom_range(4096);
    else                group_score = longint'(int'($urandom));
    if (group_score > 64'sh7FFF_FFFF) group_score = 64'sh7FFF_FFFF;
    if (group_score < -64'sh8000_0000) group_score = -64'sh8000_0000;
    return int'(group_score);
  endfunction

  function automatic in_item_t random_beat();
    int unsigned eff, rank, u, v;
    bit start;
    eff   = (node_setting > MAX_NODES) ? MAX_NODES : node_setting;
    start = ($urandom_range(39) == 0);
    if (start) group_score = -longint'($urandom_range(1 << 24));
    if (eff == 0 || $urandom_range(19) == 0) rank = $urandom_range(1023);
    else rank = $urandom_range(eff - 1);
    case ($urandom_range(3))
      0: u = 16'hFFFF;
      1: u = $urandom_range(255);
      default: u = $urandom_range(16'hFFFF);
    endcase
    v = ($urandom_range(7) == 0) ? 0 : $urandom_range(16'hFFFF);
    return make_beat(start, rank, next_score(), u, v);
  endfunction

  task automatic random_phase(input int count, input bit squeeze);
    int sent;
    sent = 0;
    while (sent < count) begin
      int burst;
      burst = $urandom_range(12, 1);
      for (int i = 0; i < burst && sent < count; i++) begin
        if (squeeze && sent == count / 2) long_hold_req = 1'b1;
        send_beat(random_beat());
        sent++;
      end
      if ($urandom_range(2) != 0) idle_sender($urandom_range(20, 1));
    end
  endtask

  initial begin
    int unsigned sizes [8] = '{1024, 0, 2047, 7, 1000, 1536, 3, 2};
    group_score = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset size of one node: the only rank in range and one just above it.
    send_beat(make_beat(1'b1, 0, 0, 16'h0100, 16'h0100));
    send_beat(make_beat(1'b0, 1, 5, 16'h0100, 16'h0100));
    send_beat(make_beat(1'b0, 0, 5, 16'hFFFF, 16'hFFFF));

    // Full tree: edge ranks, score extremes, ties, broken order, zero weights.
    set_node_count(1024);
    send_beat(make_beat(1'b1, 0,    32'sh8000_0000, 16'hFFFF, 16'hFFFF));
    send_beat(make_beat(1'b0, 1023, 32'sh8000_0000, 16'hFFFF, 16'hFFFF));
    send_beat(make_beat(1'b0, 511,  -100, 16'h0000, 16'hFFFF));
    send_beat(make_beat(1'b0, 512,  -100, 16'hFFFF, 16'h0000));
    send_beat(make_beat(1'b0, 600,  0,    16'h0100, 16'h0200));
    send_beat(make_beat(1'b0, 600,  0,    16'h0100, 16'h0300));
    send_beat(make_beat(1'b0, 700,  0,    16'h0200, 16'h0100));
    send_beat(make_beat(1'b0, 100,  -50,  16'h0300, 16'h0100));  // broken order
    send_beat(make_beat(1'b0, 1023, 32'sh7FFF_FFFF, 16'hFFFF, 16'hFFFF));
    send_beat(make_beat(1'b0, 1023, 32'sh7FFF_FFFF, 16'hFFFF, 16'hFFFF));
    send_beat(make_beat(1'b0, 0,    32'sh7FFF_FFFF, 16'hFFFF, 16'hFFFF));
    send_beat(make_beat(1'b0, 1022, 32'sh7FFF_FFFF, 16'h5555, 16'hAAAA));
    send_beat(make_beat(1'b1, 1000, 32'sh5555_5555, 16'hAAAA, 16'h5555));

    // Zero size: every rank misses; a start on a missed rank still clears.
    set_node_count(0);
    send_beat(make_beat(1'b0, 0,    0, 16'h0100, 16'h0100));
    send_beat(make_beat(1'b1, 1023, 0, 16'h0100, 16'h0100));

    // Size above the ceiling folds to the full tree without a start.
    set_node_count(2047);
    send_beat(make_beat(1'b0, 1023, 10, 16'h0100, 16'h0100));
    send_beat(make_beat(1'b0, 2,    20, 16'h0100, 16'h0100));

    // Random phases across sizes; the first one also backs the block up.
    foreach (sizes[k]) begin
      set_node_count(sizes[k]);
      random_phase(250, k == 0);
    end

    idle_sender(1);
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);

    $display("covered %0d results (%0d rank misses) over %0d tree sizes",
             seen_results, seen_rank_errors, $size(sizes) + 3);
    $display("with ties, broken order, starts, stalls and one long hold-off");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
